[hdl/point_line_mean_sq_distance_defines.svh]
// Assertion macros for the point-to-line distance block.
// Used by the top level; relies on clk and rst in the including scope.
`ifndef POINT_LINE_MEAN_SQ_DISTANCE_DEFINES_SVH
`define POINT_LINE_MEAN_SQ_DISTANCE_DEFINES_SVH

// same-cycle implication
`define PLMSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plmsd check failed");

// next-cycle implication
`define PLMSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plmsd check failed");

`endif

[hdl/plmsd_pkg.sv]
// Shared types and constants for the point-to-line distance block.
// No dependencies.
package plmsd_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int QDEPTH         = 2;
  localparam int QCNT_W         = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_X  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_Y  = 8'd3;

  // hit relative to the line point, as queued between front and back
  typedef struct packed {
    logic signed [32:0] wx;
    logic signed [32:0] wy;
    logic signed [31:0] hz;
    logic               last;
  } hit_item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } q_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_DIV,
    S_ACC,
    S_MEAN,
    S_OUT
  } back_state_t;

endpackage

[hdl/plmsd_front.sv]
// Front end: takes hit items, forms offsets from the line point, queues them.
// Depends on plmsd_pkg.
module plmsd_front
  import plmsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] hit_x,
  input  logic signed [31:0] hit_y,
  input  logic signed [31:0] hit_z,
  input  logic               last_hit,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  output logic               q_valid,
  output hit_item_t          q_item,
  input  logic               q_pop,
  output q_stat_t            q_stat
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  hit_item_t         slots [QDEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  hit_item_t         new_item;
  logic              push, pop;

  assign in_ready = (count < QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (count != '0);
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];
  assign q_stat   = '{count: count, full: !in_ready};

  always_comb begin
    new_item.wx   = 33'(hit_x) - 33'(offset_x);
    new_item.wy   = 33'(hit_y) - 33'(offset_y);
    new_item.hz   = hit_z;
    new_item.last = last_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= new_item;
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

[hdl/plmsd_back.sv]
// Back end: cross product and squares on one shared multiplier, bit-serial
// divides for distance and track mean, track accumulation, output register.
// Depends on plmsd_pkg.
module plmsd_back
  import plmsd_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] slope_x,
  input  logic signed [31:0] slope_y,
  input  logic               q_valid,
  input  hit_item_t          q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        point_distance_sq,
  output logic [63:0]        mean_distance_sq,
  output logic               mean_valid,
  output logic               too_many_hits
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [4:0] STEP_DEN0  = 5'd5;
  localparam logic [4:0] STEP_DEN1  = 5'd6;
  localparam logic [4:0] STEP_CROSS = 5'd7;
  localparam logic [4:0] STEP_LAST  = 5'd17;

  back_state_t state, state_next;

  logic [4:0]          step;
  logic signed [32:0]  wx, wy;
  logic signed [31:0]  hz;
  logic                last;
  logic signed [32:0]  op_a, op_b;
  logic signed [65:0]  prod;
  logic signed [65:0]  p_hzsy, p_hzsx, p_wxsy, p_wysx;
  logic [63:0]         den;
  logic [63:0]         mag [3];
  logic [129:0]        num;
  logic [63:0]         rem;
  logic [5:0]          bcnt;
  logic [63:0]         pt_dist;
  logic [63:0]         sum;
  logic [CW-1:0]       cnt;
  logic                ovf;
  logic [63:0]         msh;
  logic [CW-1:0]       mrem, mdiv;
  logic                tr_ovf;

  logic                out_load;
  logic                dsat;
  logic [64:0]         rem_sh;
  logic                rem_ge;
  logic [CW:0]         mrem_sh;
  logic                mrem_ge;
  logic [64:0]         sum_add;
  logic [63:0]         sum_new;
  logic [CW-1:0]       cnt_new;
  logic                ovf_new;
  logic                counted;
  logic signed [65:0]  cx, cy, cz;
  logic [1:0]          sq_part;

  function automatic logic [63:0] abs66(input logic signed [65:0] v);
    logic signed [65:0] a;
    a = v[65] ? -v : v;
    return a[63:0];
  endfunction

  // multiplier operand selection per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      5'd0:  begin op_a = 33'(hz);      op_b = 33'(slope_y); end
      5'd1:  begin op_a = 33'(hz);      op_b = 33'(slope_x); end
      5'd2:  begin op_a = wx;           op_b = 33'(slope_y); end
      5'd3:  begin op_a = wy;           op_b = 33'(slope_x); end
      5'd4:  begin op_a = 33'(slope_x); op_b = 33'(slope_x); end
      5'd5:  begin op_a = 33'(slope_y); op_b = 33'(slope_y); end
      5'd8:  begin op_a = {1'b0, mag[0][31:0]};  op_b = {1'b0, mag[0][31:0]};  end
      5'd9:  begin op_a = {1'b0, mag[0][31:0]};  op_b = {1'b0, mag[0][63:32]}; end
      5'd10: begin op_a = {1'b0, mag[0][63:32]}; op_b = {1'b0, mag[0][63:32]}; end
      5'd11: begin op_a = {1'b0, mag[1][31:0]};  op_b = {1'b0, mag[1][31:0]};  end
      5'd12: begin op_a = {1'b0, mag[1][31:0]};  op_b = {1'b0, mag[1][63:32]}; end
      5'd13: begin op_a = {1'b0, mag[1][63:32]}; op_b = {1'b0, mag[1][63:32]}; end
      5'd14: begin op_a = {1'b0, mag[2][31:0]};  op_b = {1'b0, mag[2][31:0]};  end
      5'd15: begin op_a = {1'b0, mag[2][31:0]};  op_b = {1'b0, mag[2][63:32]}; end
      5'd16: begin op_a = {1'b0, mag[2][63:32]}; op_b = {1'b0, mag[2][63:32]}; end
      default: ;
    endcase
  end

  // partial product weight of the square term consumed this step
  always_comb begin
    unique case (step)
      5'd9, 5'd12, 5'd15:  sq_part = 2'd0;
      5'd10, 5'd13, 5'd16: sq_part = 2'd1;
      default:             sq_part = 2'd2;
    endcase
  end

  always_comb begin
    cx = (66'(wy) <<< 16) - p_hzsy;
    cy = p_hzsx - (66'(wx) <<< 16);
    cz = p_wxsy - p_wysx;
  end

  assign dsat    = (num[129:128] != 2'd0) || (num[127:64] >= den);
  assign rem_sh  = {rem, num[63]};
  assign rem_ge  = rem_sh >= {1'b0, den};
  assign mrem_sh = {mrem, msh[63]};
  assign mrem_ge = mrem_sh >= {1'b0, mdiv};

  assign counted = cnt < CW'(MAX_POINTS);
  assign sum_add = {1'b0, sum} + {1'b0, pt_dist};
  assign sum_new = counted ? (sum_add[64] ? '1 : sum_add[63:0]) : sum;
  assign cnt_new = counted ? cnt + 1'b1 : cnt;
  assign ovf_new = ovf || !counted;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid) state_next = S_MUL;
      S_MUL:  if (step == STEP_LAST) state_next = S_CHK;
      S_CHK:  state_next = dsat ? S_ACC : S_DIV;
      S_DIV:  if (bcnt == '1) state_next = S_ACC;
      S_ACC:  state_next = (last && cnt_new != '0) ? S_MEAN : S_OUT;
      S_MEAN: if (bcnt == '1) state_next = S_OUT;
      S_OUT:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == S_IDLE) && q_valid;
    out_load = (state == S_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      cnt       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      step      <= '0;
      bcnt      <= '0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (q_valid) begin
            wx   <= q_item.wx;
            wy   <= q_item.wy;
            hz   <= q_item.hz;
            last <= q_item.last;
          end
        end
        S_MUL: begin
          step <= step + 1'b1;
          prod <= op_a * op_b;
          priority case (1'b1)
            step == 5'd1:       p_hzsy <= prod;
            step == 5'd2:       p_hzsx <= prod;
            step == 5'd3:       p_wxsy <= prod;
            step == 5'd4:       p_wysx <= prod;
            step == STEP_DEN0:  den <= prod[63:0] + 64'h1_0000_0000;
            step == STEP_DEN1:  den <= den + prod[63:0];
            step == STEP_CROSS: begin
              mag[0] <= abs66(cx);
              mag[1] <= abs66(cy);
              mag[2] <= abs66(cz);
              num    <= '0;
            end
            step > STEP_CROSS + 5'd1: begin
              unique case (sq_part)
                2'd0:    num <= num + 130'(prod[63:0]);
                2'd1:    num <= num + (130'(prod[63:0]) << 33);
                default: num <= num + (130'(prod[63:0]) << 64);
              endcase
            end
            default: ;
          endcase
        end
        S_CHK: begin
          bcnt <= '0;
          rem  <= num[127:64];
          if (dsat) pt_dist <= '1;
        end
        S_DIV: begin
          bcnt <= bcnt + 1'b1;
          rem  <= rem_ge ? 64'(rem_sh - {1'b0, den}) : rem_sh[63:0];
          num[63:0] <= {num[62:0], rem_ge};
          if (bcnt == '1) pt_dist <= {num[62:0], rem_ge};
        end
        S_ACC: begin
          bcnt   <= '0;
          tr_ovf <= ovf_new;
          if (last) begin
            sum  <= '0;
            cnt  <= '0;
            ovf  <= 1'b0;
            msh  <= sum_new;
            mdiv <= cnt_new;
            mrem <= '0;
          end else begin
            sum <= sum_new;
            cnt <= cnt_new;
            ovf <= ovf_new;
            msh <= '0;
          end
        end
        S_MEAN: begin
          bcnt <= bcnt + 1'b1;
          mrem <= mrem_ge ? CW'(mrem_sh - {1'b0, mdiv}) : mrem_sh[CW-1:0];
          msh  <= {msh[62:0], mrem_ge};
        end
        S_OUT: begin
          if (out_load) begin
            point_distance_sq <= pt_dist;
            mean_distance_sq  <= msh;
            mean_valid        <= last;
            too_many_hits     <= tr_ovf;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/point_line_mean_sq_distance.sv]
// Top level of the point-to-line squared distance block: configuration
// registers, front queue and back datapath. Depends on plmsd_pkg,
// plmsd_front, plmsd_back and the assertion macro header.
//
//  channel  | direction | tdata (low bit up)                  | tlast      | tuser
//  s_axis   | in        | hit_x, hit_y, hit_z                 | last_hit   | -
//  m_axis   | out       | point_distance_sq, mean_distance_sq | mean_valid | too_many_hits
//  cfg      | in        | cfg_index, cfg_data (32 bit)        | -          | -
//
// In the back end a hit passes through the shared 33x33 multiplier (cross
// product, |v|^2, squares), a saturation check, the bit-serial distance
// divide (skipped on saturation), then accumulate and output. A last hit
// also runs the serial mean divide. The two-item queue and output register
// let input and output stall independently. Synchronous reset clears track
// state and registers; configuration is always ready.
`include "point_line_mean_sq_distance_defines.svh"

module point_line_mean_sq_distance
  import plmsd_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,  // hit_x, hit_y, hit_z
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [127:0]         m_axis_tdata,  // point_distance_sq, mean_distance_sq
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser,  // too_many_hits
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic signed [31:0] offset_x, slope_x, offset_y, slope_y;
  logic               q_valid, q_pop;
  hit_item_t          q_item;
  q_stat_t            q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      slope_x  <= '0;
      offset_y <= '0;
      slope_y  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_OFFSET_X) offset_x <= cfg_data;
      if (cfg_index == REG_SLOPE_X)  slope_x  <= cfg_data;
      if (cfg_index == REG_OFFSET_Y) offset_y <= cfg_data;
      if (cfg_index == REG_SLOPE_Y)  slope_y  <= cfg_data;
    end
  end

  plmsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .hit_x    (s_axis_tdata[31:0]),
    .hit_y    (s_axis_tdata[63:32]),
    .hit_z    (s_axis_tdata[95:64]),
    .last_hit (s_axis_tlast),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .q_stat   (q_stat)
  );

  plmsd_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .slope_x           (slope_x),
    .slope_y           (slope_y),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .point_distance_sq (m_axis_tdata[63:0]),
    .mean_distance_sq  (m_axis_tdata[127:64]),
    .mean_valid        (m_axis_tlast),
    .too_many_hits     (m_axis_tuser)
  );

  `PLMSD_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
  `PLMSD_ASSERT_NOW(a_q_full_stall, q_stat.full, !s_axis_tready)
  `PLMSD_ASSERT_NOW(a_mean_zero, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[127:64] == 64'd0)

endmodule
